// ===== src/pressure_reaction_sequencer_assert.svh =====
// Assertion macros for the pressure reaction sequencer.
// Used by the top level; expects clk and rst in scope.
`ifndef PRESSURE_REACTION_SEQUENCER_ASSERT_SVH
`define PRESSURE_REACTION_SEQUENCER_ASSERT_SVH

// same-cycle implication
`define PRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prs same-cycle check failed");

// next-cycle implication
`define PRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prs next-cycle check failed");

`endif

// ===== src/prs_pkg.sv =====
// Types and constants of the pressure reaction sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package prs_pkg;

  localparam int ERR_W = 13;

  typedef enum logic [2:0] {
    PH_INIT    = 3'd0,
    PH_MONITOR = 3'd1,
    PH_CROUCH  = 3'd2,
    PH_HOLD    = 3'd3,
    PH_RETURN  = 3'd4,
    PH_COOL    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_CROUCH = 2'd1,
    CMD_STANCE = 2'd2
  } move_cmd_t;

  typedef enum logic [2:0] {
    REG_STANCE   = 3'd0,
    REG_CROUCH   = 3'd1,
    REG_DEADZONE = 3'd2,
    REG_TRIGGER  = 3'd3,
    REG_HOLD     = 3'd4,
    REG_RETURN   = 3'd5,
    REG_COOLDOWN = 3'd6,
    REG_PERIOD   = 3'd7
  } cfg_index_t;

  localparam logic [15:0]        INIT_WAIT_MS   = 16'd1000;
  localparam logic [15:0]        CROUCH_WAIT_MS = 16'd350;
  localparam logic [9:0]         MOVE_SPEED     = 10'd500;
  localparam logic signed [13:0] MIRROR_SPAN    = 14'sd3600;
  localparam logic [15:0]        PHASE_TIMER_MAX  = 16'hFFFF;
  localparam logic [9:0]         UPDATE_TIMER_MAX = 10'h3FF;

  typedef struct packed {
    logic [11:0] stance_angle;
    logic [11:0] crouch_amount;
    logic [11:0] dead_zone;
    logic [11:0] trigger_level;
    logic [15:0] hold_time_ms;
    logic [15:0] return_wait_ms;
    logic [15:0] cooldown_time_ms;
    logic [9:0]  update_period_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    stance_angle:     12'd2700,
    crouch_amount:    12'd350,
    dead_zone:        12'd2,
    trigger_level:    12'd0,
    hold_time_ms:     16'd400,
    return_wait_ms:   16'd400,
    cooldown_time_ms: 16'd2000,
    update_period_ms: 10'd25
  };

  typedef struct packed {
    logic [11:0] left_raw_angle;
    logic [11:0] right_raw_angle;
    logic        angles_valid;
    logic        enable_level;
  } sample_t;

  typedef struct packed {
    move_cmd_t   move_command;
    logic [11:0] target_angle;
    logic [9:0]  move_speed;
    logic        is_crouched;
    logic [11:0] crouch_offset;
    phase_t      phase;
    logic        is_enabled;
  } result_t;

endpackage

`default_nettype wire

// ===== src/prs_sample_if.sv =====
// Input channel of the pressure reaction sequencer: one tick word.
// No dependencies.
`default_nettype none

interface prs_sample_if;
  logic        valid;
  logic        ready;
  logic [11:0] left_raw_angle;
  logic [11:0] right_raw_angle;
  logic        angles_valid;
  logic        enable_level;

  modport source (
    output valid, left_raw_angle, right_raw_angle, angles_valid, enable_level,
    input  ready
  );

  modport sink (
    input  valid, left_raw_angle, right_raw_angle, angles_valid, enable_level,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/prs_result_if.sv =====
// Output channel of the pressure reaction sequencer: one result word per tick.
// No dependencies.
`default_nettype none

interface prs_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  move_command;
  logic [11:0] target_angle;
  logic [9:0]  move_speed;
  logic        is_crouched;
  logic [11:0] crouch_offset;
  logic [2:0]  phase;
  logic        is_enabled;

  modport source (
    output valid, move_command, target_angle, move_speed, is_crouched,
           crouch_offset, phase, is_enabled,
    input  ready
  );

  modport sink (
    input  valid, move_command, target_angle, move_speed, is_crouched,
           crouch_offset, phase, is_enabled,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/prs_error.sv =====
// Leg deviation error: mirrors the right angle, takes the larger deviation
// from stance and applies the dead zone; zero when angles are invalid. Depends on prs_pkg.
`default_nettype none

module prs_error
  import prs_pkg::*;
(
  input  wire logic [11:0]      left_raw_angle,
  input  wire logic [11:0]      right_raw_angle,
  input  wire logic             angles_valid,
  input  wire logic [11:0]      stance_angle,
  input  wire logic [11:0]      dead_zone,
  output logic      [ERR_W-1:0] err
);

  logic signed [13:0] left_dev;
  logic signed [13:0] mirror;
  logic signed [13:0] right_dev;
  logic [ERR_W-1:0]   left_abs;
  logic [ERR_W-1:0]   right_abs;
  logic [ERR_W-1:0]   err_max;

  always_comb begin
    left_dev  = $signed({2'b00, left_raw_angle}) - $signed({2'b00, stance_angle});
    mirror    = MIRROR_SPAN - $signed({2'b00, right_raw_angle});
    right_dev = mirror - $signed({2'b00, stance_angle});
    left_abs  = left_dev[13] ? ERR_W'(-left_dev) : left_dev[ERR_W-1:0];
    right_abs = right_dev[13] ? ERR_W'(-right_dev) : right_dev[ERR_W-1:0];
    err_max   = (left_abs > right_abs) ? left_abs : right_abs;
    if (!angles_valid || (err_max < {1'b0, dead_zone})) begin
      err = '0;
    end else begin
      err = err_max;
    end
  end

endmodule

`default_nettype wire

// ===== src/prs_seq.sv =====
// Sequencer state: phase, phase and update timers, enable flag. Gives the
// result word of the tick being stepped. Depends on prs_pkg.
`default_nettype none

module prs_seq
  import prs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic             enable_level,
  input  wire logic [ERR_W-1:0] err,
  input  wire cfg_t             cfg,
  output result_t               res_next
);

  phase_t      phase_reg;
  logic [15:0] phase_timer;
  logic [9:0]  update_timer;
  logic        enabled_flag;

  phase_t      phase_next;
  logic [15:0] phase_timer_next;
  logic [9:0]  update_timer_next;

  phase_t      phase_edge;
  logic [15:0] timer_edge;
  logic [9:0]  update_inc;
  logic        en_rise;
  logic        en_fall;
  logic        eval;
  logic        crouch_go;
  logic        return_go;
  logic [11:0] crouch_target;

  assign en_rise    = enable_level && !enabled_flag;
  assign en_fall    = !enable_level && enabled_flag;
  assign update_inc = (update_timer != UPDATE_TIMER_MAX) ? update_timer + 10'd1
                                                         : update_timer;
  assign phase_edge = en_rise ? PH_COOL : phase_reg;
  assign timer_edge = en_rise ? 16'd0 :
                      (phase_timer != PHASE_TIMER_MAX) ? phase_timer + 16'd1 : phase_timer;
  assign eval       = enable_level && (update_inc >= cfg.update_period_ms);
  assign crouch_go  = eval && (phase_edge == PH_MONITOR) && (err > {1'b0, cfg.trigger_level});
  assign return_go  = eval && (phase_edge == PH_HOLD) && (timer_edge > cfg.hold_time_ms);
  assign crouch_target = (cfg.crouch_amount > cfg.stance_angle) ? 12'd0
                       : cfg.stance_angle - cfg.crouch_amount;

  always_comb begin
    phase_next        = phase_edge;
    phase_timer_next  = timer_edge;
    update_timer_next = eval ? 10'd0 : update_inc;
    if (eval) begin
      unique case (phase_edge)
        PH_INIT: begin
          if (timer_edge > INIT_WAIT_MS) phase_next = PH_MONITOR;
        end
        PH_MONITOR: begin
          if (crouch_go) phase_next = PH_CROUCH;
        end
        PH_CROUCH: begin
          if (timer_edge > CROUCH_WAIT_MS) phase_next = PH_HOLD;
        end
        PH_HOLD: begin
          if (return_go) phase_next = PH_RETURN;
        end
        PH_RETURN: begin
          if (timer_edge > cfg.return_wait_ms) phase_next = PH_COOL;
        end
        PH_COOL: begin
          if (timer_edge > cfg.cooldown_time_ms) phase_next = PH_MONITOR;
        end
        default: phase_next = phase_edge;
      endcase
    end
    if (phase_next != phase_edge) phase_timer_next = 16'd0;
  end

  always_comb begin
    res_next.move_command = CMD_NONE;
    res_next.target_angle = 12'd0;
    res_next.move_speed   = 10'd0;
    if (en_fall || return_go) begin
      res_next.move_command = CMD_STANCE;
      res_next.target_angle = cfg.stance_angle;
      res_next.move_speed   = MOVE_SPEED;
    end else if (crouch_go) begin
      res_next.move_command = CMD_CROUCH;
      res_next.target_angle = crouch_target;
      res_next.move_speed   = MOVE_SPEED;
    end
    res_next.is_crouched   = (phase_next == PH_CROUCH) || (phase_next == PH_HOLD);
    res_next.crouch_offset = res_next.is_crouched ? cfg.crouch_amount : 12'd0;
    res_next.phase         = phase_next;
    res_next.is_enabled    = enable_level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg    <= PH_INIT;
      phase_timer  <= 16'd0;
      update_timer <= 10'd0;
      enabled_flag <= 1'b1;
    end else if (step) begin
      phase_reg    <= phase_next;
      phase_timer  <= phase_timer_next;
      update_timer <= update_timer_next;
      enabled_flag <= enable_level;
    end
  end

endmodule

`default_nettype wire

// ===== src/pressure_reaction_sequencer.sv =====
// Pressure reaction sequencer: takes one tick word per clock cycle while the
// output is not stalled, one word in flight in the input register and one in
// the result register; the result word of a tick is registered in the result
// register. A tick is taken in every cycle in which the input register is
// empty or passes its word on, and the input register passes its word on in
// every cycle in which the result register is free or being emptied. The rate
// is set by the single evaluation path from the input register through the
// error unit and the phase sequencer into the result register.
// Depends on prs_pkg, prs_sample_if, prs_result_if, prs_error, prs_seq and the
// assertion macro header.
`default_nettype none

`include "pressure_reaction_sequencer_assert.svh"

module pressure_reaction_sequencer
  import prs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  prs_sample_if.sink       sample,
  prs_result_if.source     result
);

  cfg_t             cfg;
  sample_t          s1;
  logic             s1_valid;
  result_t          res;
  logic             res_valid;
  result_t          res_next;
  logic             advance;
  logic [ERR_W-1:0] err;

  assign advance      = s1_valid && (!res_valid || result.ready);
  assign sample.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        REG_STANCE:   cfg.stance_angle     <= cfg_data[11:0];
        REG_CROUCH:   cfg.crouch_amount    <= cfg_data[11:0];
        REG_DEADZONE: cfg.dead_zone        <= cfg_data[11:0];
        REG_TRIGGER:  cfg.trigger_level    <= cfg_data[11:0];
        REG_HOLD:     cfg.hold_time_ms     <= cfg_data;
        REG_RETURN:   cfg.return_wait_ms   <= cfg_data;
        REG_COOLDOWN: cfg.cooldown_time_ms <= cfg_data;
        REG_PERIOD:   cfg.update_period_ms <= cfg_data[9:0];
        default:      cfg <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample.ready) begin
      s1_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s1.left_raw_angle  <= sample.left_raw_angle;
      s1.right_raw_angle <= sample.right_raw_angle;
      s1.angles_valid    <= sample.angles_valid;
      s1.enable_level    <= sample.enable_level;
    end
  end

  prs_error u_error (
    .left_raw_angle  (s1.left_raw_angle),
    .right_raw_angle (s1.right_raw_angle),
    .angles_valid    (s1.angles_valid),
    .stance_angle    (cfg.stance_angle),
    .dead_zone       (cfg.dead_zone),
    .err             (err)
  );

  prs_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .enable_level (s1.enable_level),
    .err          (err),
    .cfg          (cfg),
    .res_next     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid         = res_valid;
  assign result.move_command  = res.move_command;
  assign result.target_angle  = res.target_angle;
  assign result.move_speed    = res.move_speed;
  assign result.is_crouched   = res.is_crouched;
  assign result.crouch_offset = res.crouch_offset;
  assign result.phase         = res.phase;
  assign result.is_enabled    = res.is_enabled;

  `PRS_ASSERT_NOW(a_stall_blocks_input, s1_valid && res_valid && !result.ready, !sample.ready)
  `PRS_ASSERT_NOW(a_cmd_has_speed, res_valid && (res.move_command != CMD_NONE), res.move_speed == MOVE_SPEED)
  `PRS_ASSERT_NOW(a_crouch_phase, res_valid && (res.move_command == CMD_CROUCH), res.phase == PH_CROUCH)
  `PRS_ASSERT_NEXT(a_advance_fills, advance, res_valid)

endmodule

`default_nettype wire
